>>> hdl/sqcf_pkg.sv
// ----------------------------------------------------------------------------
// Square root continued fraction package
// Shared widths and the command and status words between controller and
// datapath.
// ----------------------------------------------------------------------------
package sqcf_pkg;

  localparam int RAD_IN_W = 32;
  localparam int TERM_W   = 17;

  typedef struct packed {
    logic sqrt_init;
    logic sqrt_step;
    logic div_init_k;
    logic div_init_b;
    logic div_step;
    logic mul_kb;
    logic calc_na;
    logic mul_sq;
    logic fin_start;
    logic fin_next;
    logic fin_err;
  } cmd_t;

  typedef struct packed {
    logic active;
    logic div_zero;
    logic iter_done;
  } sts_t;

endpackage

>>> hdl/sqcf_if.sv
// ----------------------------------------------------------------------------
// Square root continued fraction channels
// Request and result channels with a valid and ready handshake.
// ----------------------------------------------------------------------------
interface sqcf_req_if import sqcf_pkg::*; ();
  logic                valid;
  logic                ready;
  logic                req_type;
  logic [RAD_IN_W-1:0] radicand;

  modport source (output valid, output req_type, output radicand, input ready);
  modport sink   (input valid, input req_type, input radicand, output ready);
endinterface

interface sqcf_res_if import sqcf_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [TERM_W-1:0] term;
  logic              is_last;
  logic              status;

  modport source (output valid, output term, output is_last, output status, input ready);
  modport sink   (input valid, input term, input is_last, input status, output ready);
endinterface

>>> hdl/sqcf_datapath.sv
// ----------------------------------------------------------------------------
// Square root continued fraction datapath
// Expansion state, digit-serial square root, shared restoring divider,
// shared multiplier and the result word register.
// ----------------------------------------------------------------------------
module sqcf_datapath import sqcf_pkg::*; #(
  parameter int RADICAND_BITS = 32
) (
  input  logic                clk,
  input  logic                rst_n,
  input  cmd_t                cmd,
  input  logic [RAD_IN_W-1:0] radicand,
  output sts_t                sts,
  output logic [TERM_W-1:0]   term,
  output logic                is_last,
  output logic                status
);

  localparam int D   = RADICAND_BITS;
  localparam int R   = (D + 1) / 2;
  localparam int B   = R + 1;
  localparam int W2  = 2 * R;
  localparam int DSW = 2 * R + 1;
  localparam int PW  = 2 * B;
  localparam int CW  = $clog2(B);

  logic [D-1:0]      d_r;
  logic [R-1:0]      root_r;
  logic [R-1:0]      fa_r;
  logic [B-1:0]      fb_r;
  logic [R-1:0]      ca_r;
  logic [B-1:0]      cb_r;
  logic              active_r;

  logic [W2-1:0]     sx_r;
  logic [W2-1:0]     sr_r;
  logic [W2-1:0]     sbit_r;
  logic [W2-1:0]     rem_r;
  logic [DSW-1:0]    ds_r;
  logic [B-1:0]      q_r;
  logic [B-1:0]      k_r;
  logic [R-1:0]      na_r;
  logic [PW-1:0]     prod_r;
  logic [CW-1:0]     cnt_r;

  logic [TERM_W-1:0] term_r;
  logic              last_r;
  logic              status_r;

  logic [W2-1:0]     sq_sum;
  logic              sq_take;
  logic [R-1:0]      sq_root;
  logic [B-1:0]      sq_rem;
  logic [DSW-1:0]    rem_ext;
  logic              dv_take;
  logic [DSW-1:0]    dv_diff;
  logic [B-1:0]      mul_a;
  logic [B-1:0]      mul_b;
  logic [PW-1:0]     mul_p;
  logic              period_end;

  assign sq_sum     = sr_r + sbit_r;
  assign sq_take    = sx_r >= sq_sum;
  assign sq_root    = sr_r[R-1:0];
  assign sq_rem     = sx_r[B-1:0];
  assign rem_ext    = {1'b0, rem_r};
  assign dv_take    = rem_ext >= ds_r;
  assign dv_diff    = rem_ext - ds_r;
  assign mul_a      = cmd.mul_sq ? B'(na_r) : q_r;
  assign mul_b      = cmd.mul_sq ? B'(na_r) : cb_r;
  assign mul_p      = PW'(mul_a) * PW'(mul_b);
  assign period_end = (na_r == fa_r) && (q_r == fb_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d_r      <= '0;
      root_r   <= '0;
      fa_r     <= '0;
      fb_r     <= '0;
      ca_r     <= '0;
      cb_r     <= '0;
      active_r <= 1'b0;
    end else begin
      if (cmd.sqrt_init) begin
        d_r <= D'(radicand);
      end
      if (cmd.fin_start) begin
        root_r   <= sq_root;
        fa_r     <= sq_root;
        ca_r     <= sq_root;
        fb_r     <= sq_rem;
        cb_r     <= sq_rem;
        active_r <= (sq_rem != '0);
      end else if (cmd.fin_next) begin
        ca_r <= na_r;
        cb_r <= q_r;
        if (period_end) begin
          active_r <= 1'b0;
        end
      end else if (cmd.fin_err) begin
        active_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.sqrt_init) begin
      sx_r   <= W2'(D'(radicand));
      sr_r   <= '0;
      sbit_r <= W2'(1) << (W2 - 2);
    end else if (cmd.sqrt_step) begin
      if (sq_take) begin
        sx_r <= sx_r - sq_sum;
        sr_r <= (sr_r >> 1) + sbit_r;
      end else begin
        sr_r <= sr_r >> 1;
      end
      sbit_r <= sbit_r >> 2;
    end

    if (cmd.div_init_k) begin
      rem_r <= W2'(B'(root_r) + B'(ca_r));
      ds_r  <= DSW'(cb_r) << R;
      q_r   <= '0;
    end else if (cmd.div_init_b) begin
      rem_r <= W2'(d_r) - W2'(prod_r);
      ds_r  <= DSW'(cb_r) << R;
      q_r   <= '0;
    end else if (cmd.div_step) begin
      if (dv_take) begin
        rem_r <= W2'(dv_diff);
      end
      q_r  <= {q_r[B-2:0], dv_take};
      ds_r <= ds_r >> 1;
    end

    if (cmd.sqrt_init) begin
      cnt_r <= CW'(R - 1);
    end else if (cmd.div_init_k || cmd.div_init_b) begin
      cnt_r <= CW'(B - 1);
    end else if (cmd.sqrt_step || cmd.div_step) begin
      cnt_r <= cnt_r - CW'(1);
    end

    if (cmd.mul_kb) begin
      k_r <= q_r;
    end
    if (cmd.mul_kb || cmd.mul_sq) begin
      prod_r <= mul_p;
    end
    if (cmd.calc_na) begin
      na_r <= R'(prod_r - PW'(ca_r));
    end

    if (cmd.fin_start) begin
      term_r   <= TERM_W'(sq_root);
      last_r   <= (sq_rem == '0);
      status_r <= 1'b0;
    end else if (cmd.fin_next) begin
      term_r   <= TERM_W'(k_r);
      last_r   <= period_end;
      status_r <= 1'b0;
    end else if (cmd.fin_err) begin
      term_r   <= '0;
      last_r   <= 1'b0;
      status_r <= 1'b1;
    end
  end

  assign sts.active    = active_r;
  assign sts.div_zero  = (cb_r == '0);
  assign sts.iter_done = (cnt_r == '0);

  assign term    = term_r;
  assign is_last = last_r;
  assign status  = status_r;

endmodule

>>> hdl/sqcf_ctrl.sv
// ----------------------------------------------------------------------------
// Square root continued fraction controller
// Sequences the root, divide and multiply steps and owns the handshakes.
// ----------------------------------------------------------------------------
module sqcf_ctrl import sqcf_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  input  logic in_req_type,
  input  logic out_ready,
  input  sts_t sts,
  output cmd_t cmd,
  output logic in_ready,
  output logic out_valid
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_SQRT,
    S_DIV1,
    S_MULKB,
    S_NA,
    S_MULSQ,
    S_DIVB,
    S_DIV2,
    S_FIN_S,
    S_FIN_N,
    S_FIN_E
  } state_t;

  state_t state_r;
  state_t state_nxt;
  logic   out_valid_r;
  logic   out_valid_nxt;
  logic   slot_free;

  assign slot_free = !out_valid_r || out_ready;
  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    cmd           = '0;
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && !out_ready;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          if (!in_req_type) begin
            cmd.sqrt_init = 1'b1;
            state_nxt     = S_SQRT;
          end else if (sts.active && !sts.div_zero) begin
            cmd.div_init_k = 1'b1;
            state_nxt      = S_DIV1;
          end else begin
            state_nxt = S_FIN_E;
          end
        end
      end
      S_SQRT: begin
        cmd.sqrt_step = 1'b1;
        if (sts.iter_done) begin
          state_nxt = S_FIN_S;
        end
      end
      S_DIV1: begin
        cmd.div_step = 1'b1;
        if (sts.iter_done) begin
          state_nxt = S_MULKB;
        end
      end
      S_MULKB: begin
        cmd.mul_kb = 1'b1;
        state_nxt  = S_NA;
      end
      S_NA: begin
        cmd.calc_na = 1'b1;
        state_nxt   = S_MULSQ;
      end
      S_MULSQ: begin
        cmd.mul_sq = 1'b1;
        state_nxt  = S_DIVB;
      end
      S_DIVB: begin
        cmd.div_init_b = 1'b1;
        state_nxt      = S_DIV2;
      end
      S_DIV2: begin
        cmd.div_step = 1'b1;
        if (sts.iter_done) begin
          state_nxt = S_FIN_N;
        end
      end
      S_FIN_S: begin
        if (slot_free) begin
          cmd.fin_start = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      S_FIN_N: begin
        if (slot_free) begin
          cmd.fin_next  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      S_FIN_E: begin
        if (slot_free) begin
          cmd.fin_err   = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

>>> hdl/sqrt_continued_fraction_terms.sv
// ----------------------------------------------------------------------------
// Continued fraction terms of a square root
// A start word returns floor(sqrt(d)); each next word returns one partial
// quotient of the periodic expansion, or an error word if none is active.
// ----------------------------------------------------------------------------
// A start word is produced by the digit-serial root (one root bit per cycle)
// and then waits for a free result slot. A next word is set by two passes of
// the shared restoring divider (one quotient bit per cycle) and the shared
// multiplier. A refused next word gives an error status word. A new word is
// taken once the controller is back in idle, as the result word turns valid.
// Reset clears all expansion state; no expansion is active afterwards.
module sqrt_continued_fraction_terms import sqcf_pkg::*; #(
  parameter int RADICAND_BITS = 32
) (
  input  logic       clk,
  input  logic       rst_n,
  sqcf_req_if.sink   in_req,
  sqcf_res_if.source out_res
);

  cmd_t cmd;
  sts_t sts;

  sqcf_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_req.valid),
    .in_req_type (in_req.req_type),
    .out_ready   (out_res.ready),
    .sts         (sts),
    .cmd         (cmd),
    .in_ready    (in_req.ready),
    .out_valid   (out_res.valid)
  );

  sqcf_datapath #(
    .RADICAND_BITS (RADICAND_BITS)
  ) u_datapath (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .radicand (in_req.radicand),
    .sts      (sts),
    .term     (out_res.term),
    .is_last  (out_res.is_last),
    .status   (out_res.status)
  );

endmodule

>>> verif/sqcf_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Square root continued fraction checker
// Watches the request and result channels, keeps its own copy of the
// expansion state to work out each expected term word, and compares every
// accepted result word field by field with the oldest one outstanding.
// ----------------------------------------------------------------------------
package sqcf_tb_pkg;
  import sqcf_pkg::*;

  localparam logic REQ_START = 1'b0;
  localparam logic REQ_NEXT  = 1'b1;

  localparam logic ST_OK           = 1'b0;
  localparam logic ST_NO_EXPANSION = 1'b1;
endpackage

module sqcf_checker import sqcf_pkg::*; import sqcf_tb_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  sqcf_req_if         req,
  sqcf_res_if         res,
  output int unsigned mismatch_count,
  output int unsigned pending_words
);

  localparam int ROOT_W = (RAD_IN_W + 1) / 2;
  localparam int DIV_W  = ROOT_W + 1;

  typedef struct packed {
    logic [TERM_W-1:0] term;
    logic              is_last;
    logic              status;
  } cf_word_t;

  cf_word_t expected_terms[$];

  logic [RAD_IN_W-1:0] held_radicand;
  logic [ROOT_W-1:0]   int_root;
  logic [ROOT_W-1:0]   start_offset;
  logic [DIV_W-1:0]    start_divisor;
  logic [ROOT_W-1:0]   offset;
  logic [DIV_W-1:0]    divisor;
  logic                expanding;

  function automatic logic [ROOT_W-1:0] floor_root(input logic [RAD_IN_W-1:0] x);
    logic [ROOT_W-1:0] r;
    logic [ROOT_W-1:0] cand;
    logic [63:0]       sq;
    r = '0;
    for (int i = ROOT_W - 1; i >= 0; i--) begin
      cand = r | (ROOT_W'(1) << i);
      sq   = 64'(cand) * 64'(cand);
      if (sq <= 64'(x)) r = cand;
    end
    return r;
  endfunction

  function automatic cf_word_t predict_term(input logic kind, input logic [RAD_IN_W-1:0] d);
    cf_word_t    w;
    logic [63:0] r64;
    logic [63:0] b64;
    logic [63:0] k64;
    logic [63:0] na64;
    logic [63:0] nb64;
    w = '0;
    w.status = ST_OK;
    if (kind == REQ_START) begin
      r64           = 64'(floor_root(d));
      b64           = 64'(d) - r64 * r64;
      held_radicand = d;
      int_root      = r64[ROOT_W-1:0];
      start_offset  = r64[ROOT_W-1:0];
      start_divisor = b64[DIV_W-1:0];
      offset        = r64[ROOT_W-1:0];
      divisor       = b64[DIV_W-1:0];
      expanding     = (b64 != 0);
      w.term        = r64[TERM_W-1:0];
      w.is_last     = (b64 == 0);
    end else if (!expanding || divisor == '0) begin
      expanding = 1'b0;
      w.status  = ST_NO_EXPANSION;
    end else begin
      k64     = (64'(int_root) + 64'(offset)) / 64'(divisor);
      na64    = k64 * 64'(divisor) - 64'(offset);
      nb64    = (64'(held_radicand) - na64 * na64) / 64'(divisor);
      offset  = na64[ROOT_W-1:0];
      divisor = nb64[DIV_W-1:0];
      w.term  = k64[TERM_W-1:0];
      if (na64 == 64'(start_offset) && nb64 == 64'(start_divisor)) begin
        w.is_last = 1'b1;
        expanding = 1'b0;
      end
    end
    return w;
  endfunction

  task automatic enqueue_word(input cf_word_t w);
    expected_terms.insert(expected_terms.size(), w);
  endtask

  task automatic report_mismatch(input string msg);
    mismatch_count++;
    $display("[%0t] mismatch: %s", $realtime, msg);
  endtask

  always @(posedge clk) begin
    cf_word_t want;
    if (!rst_n) begin
      held_radicand  = '0;
      int_root       = '0;
      start_offset   = '0;
      start_divisor  = '0;
      offset         = '0;
      divisor        = '0;
      expanding      = 1'b0;
      expected_terms.delete();
      mismatch_count = 0;
      pending_words  = 0;
    end else begin
      if (res.valid && res.ready) begin
        if (expected_terms.size() == 0) begin
          report_mismatch($sformatf("result word with none expected, term %0d", res.term));
        end else begin
          want = expected_terms.pop_front();
          if (res.term !== want.term)
            report_mismatch($sformatf("term %0d, expected %0d", res.term, want.term));
          if (res.is_last !== want.is_last)
            report_mismatch($sformatf("is_last %0b, expected %0b", res.is_last, want.is_last));
          if (res.status !== want.status)
            report_mismatch($sformatf("status %0b, expected %0b", res.status, want.status));
        end
      end
      if (req.valid && req.ready)
        enqueue_word(predict_term(req.req_type, req.radicand));
      pending_words = expected_terms.size();
    end
  end

endmodule

>>> verif/tb_sqrt_continued_fraction_terms.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Square root continued fraction testbench
// Drives start and next request words into the block, first a directed set
// and then random expansions under three idling profiles, and gives the
// verdict from the checker's mismatch count and outstanding word count.
// ----------------------------------------------------------------------------
module tb_sqrt_continued_fraction_terms;
  import sqcf_pkg::*;
  import sqcf_tb_pkg::*;

  localparam int WATCHDOG_LIMIT = 5000;
  localparam int PHASE_WORDS    = 434;

  logic        clk;
  logic        rst_n;
  int unsigned mismatch_count;
  int unsigned pending_words;
  int          send_idle_pct;
  int          recv_idle_pct;
  int          quiet_cycles;

  sqcf_req_if in_req_ch ();
  sqcf_res_if out_res_ch ();

  sqrt_continued_fraction_terms u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_req (in_req_ch),
    .out_res(out_res_ch)
  );

  sqcf_checker u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .req           (in_req_ch),
    .res           (out_res_ch),
    .mismatch_count(mismatch_count),
    .pending_words (pending_words)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  always @(negedge clk) begin
    out_res_ch.ready = ($urandom_range(0, 99) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    if (!rst_n || (in_req_ch.valid && in_req_ch.ready) ||
        (out_res_ch.valid && out_res_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Called at a falling edge; returns at the falling edge after acceptance
  // with valid still high, so that back-to-back words need no second write.
  task automatic send_word(input logic kind, input logic [RAD_IN_W-1:0] d);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_req_ch.valid = 1'b0;
      @(negedge clk);
    end
    in_req_ch.valid    = 1'b1;
    in_req_ch.req_type = kind;
    in_req_ch.radicand = d;
    do @(posedge clk); while (!in_req_ch.ready);
    @(negedge clk);
  endtask

  task automatic drain_results();
    in_req_ch.valid = 1'b0;
    while (pending_words != 0) @(negedge clk);
  endtask

  task automatic send_expansion(input logic [RAD_IN_W-1:0] d, input int steps, inout int sent);
    send_word(REQ_START, d);
    sent++;
    repeat (steps) begin
      send_word(REQ_NEXT, $urandom());
      sent++;
    end
  endtask

  task automatic run_random(input int words);
    int                sent;
    int                pick;
    logic [15:0]       r;
    logic [RAD_IN_W-1:0] d;
    sent = 0;
    while (sent < words) begin
      pick = $urandom_range(0, 99);
      r    = 16'($urandom_range(0, 65535));
      if (pick < 55) begin
        send_expansion($urandom_range(0, 4095), $urandom_range(0, 30), sent);
      end else if (pick < 78) begin
        send_expansion($urandom(), $urandom_range(0, 8), sent);
      end else if (pick < 86) begin
        d = RAD_IN_W'(r) * RAD_IN_W'(r);
        send_expansion(d, $urandom_range(0, 2), sent);
      end else if (pick < 94) begin
        d = RAD_IN_W'(r) * RAD_IN_W'(r);
        d = ($urandom_range(0, 1) != 0) ? d + 2 * RAD_IN_W'(r) : d + 1;
        send_expansion(d, $urandom_range(0, 20), sent);
      end else begin
        repeat ($urandom_range(1, 3)) begin
          send_word(REQ_NEXT, $urandom());
          sent++;
        end
      end
    end
  endtask

  initial begin
    in_req_ch.valid    = 1'b0;
    in_req_ch.req_type = REQ_START;
    in_req_ch.radicand = '0;
    send_idle_pct      = 0;
    recv_idle_pct      = 0;
    rst_n              = 1'b0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed words: zero and other perfect squares, next while idle,
    // the largest radicand with its widest term, and a restart mid-period.
    send_word(REQ_NEXT, 32'hFFFF_FFFF);
    send_word(REQ_START, 32'd0);
    send_word(REQ_NEXT, 32'd0);
    send_word(REQ_START, 32'd1);
    send_word(REQ_START, 32'd2);
    send_word(REQ_NEXT, 32'd0);
    send_word(REQ_NEXT, 32'd0);
    send_word(REQ_START, 32'd3);
    send_word(REQ_NEXT, 32'd0);
    send_word(REQ_NEXT, 32'd0);
    send_word(REQ_START, 32'hFFFF_FFFF);
    send_word(REQ_NEXT, 32'd0);
    send_word(REQ_NEXT, 32'd0);
    send_word(REQ_NEXT, 32'd0);
    send_word(REQ_START, 32'hFFFE_0001);
    send_word(REQ_NEXT, 32'd0);
    send_word(REQ_START, 32'd7);
    send_word(REQ_NEXT, 32'd0);
    send_word(REQ_START, 32'd5);
    send_word(REQ_NEXT, 32'd0);
    send_word(REQ_START, 32'h8000_0000);
    send_word(REQ_NEXT, 32'd0);
    send_word(REQ_START, 32'h7FFF_FFFF);
    send_word(REQ_NEXT, 32'd0);
    drain_results();

    send_idle_pct = 6;
    recv_idle_pct = 58;
    run_random(PHASE_WORDS);
    drain_results();

    send_idle_pct = 58;
    recv_idle_pct = 6;
    run_random(PHASE_WORDS);
    drain_results();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    run_random(PHASE_WORDS);
    drain_results();

    repeat (60) @(negedge clk);
    if (mismatch_count == 0 && pending_words == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
